### src/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BODY    = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_WANT_BS = 3'd4,
    MODE_WANT_U  = 3'd5,
    MODE_HEX2    = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_HEX   = 3'd1,
    ERR_BAD_SURR  = 3'd2,
    ERR_NO_QUOTE  = 3'd3,
    ERR_BAD_ESC   = 3'd4,
    ERR_CTRL_CHAR = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       code;
    logic       last;
  } res_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [15:0] SURR_HI_LO = 16'hD800;
  localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
  localparam logic [15:0] SURR_LO_LO = 16'hDC00;
  localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // {valid, value} of one ASCII hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) r = {1'b1, b[3:0]};
    else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

endpackage
`default_nettype wire

### src/json_string_unescape_utf8.sv
// A result is registered and appears in the cycle after its text byte is accepted.
// Up to one text byte per cycle while out_ready is high; a \u escape that yields
// several UTF-8 bytes holds the input while the 4-entry result buffer drains.
// Rate is set by the single output port draining the result buffer.
// Reset (rst_n low, synchronous): parser idle, hex/surrogate state cleared,
// result buffer empty.
`default_nettype none
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_start_req,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_out_byte,
  output      logic [1:0] out_kind,
  output      logic [2:0] out_error_code,
  output      logic       out_last
);

  // Parser state
  mode_t       mode_r, mode_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [9:0]  hsur_r, hsur_nxt;

  // Result buffer: loaded whole on a request, drained one entry a cycle while out_ready is high
  res_t        buf_r [4];
  res_t        res [4];
  logic [2:0]  nres;
  logic [1:0]  rd_r;
  logic [2:0]  cnt_r;

  logic        in_fire, out_fire;
  logic [4:0]  hd;
  logic [15:0] full;
  logic [20:0] cp;
  logic [20:0] surr_cp;

  assign out_valid = (cnt_r != 3'd0);
  assign out_fire  = out_valid && out_ready;
  // Take a new request when the buffer is empty or its final entry leaves now
  assign in_ready  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;

  assign hd      = hex_digit(in_text_byte);
  assign full    = {hex_r[11:0], hd[3:0]};
  assign surr_cp = {1'b0, hsur_r, full[9:0]} + SUPP_BASE;

  function automatic res_t mk(input logic [7:0] d, input kind_t k, input err_t c);
    res_t r;
    r.data = d;
    r.kind = k;
    r.code = c;
    r.last = 1'b0;
    return r;
  endfunction

  // Decode one request: next parser state plus up to four results
  always_comb begin
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    hcnt_nxt = hcnt_r;
    hsur_nxt = hsur_r;
    nres     = 3'd0;
    cp       = {5'd0, full};
    for (int i = 0; i < 4; i++) res[i] = mk(8'h00, KIND_BYTE, ERR_NONE);

    if (in_start_req) begin
      mode_nxt = MODE_BODY;
      hex_nxt  = '0;
      hcnt_nxt = '0;
      hsur_nxt = '0;
    end else begin
      case (mode_r)
        MODE_IDLE: begin
          // ignore text outside a string
        end
        MODE_BODY: begin
          if (in_text_byte == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
            res[0]   = mk(8'h00, KIND_DONE, ERR_NONE);
            nres     = 3'd1;
          end else if (in_text_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else if (in_text_byte == 8'h00) begin
            mode_nxt = MODE_IDLE;
            res[0]   = mk(8'h00, KIND_ERROR, ERR_NO_QUOTE);
            nres     = 3'd1;
          end else if (in_text_byte < CH_SPACE) begin
            mode_nxt = MODE_IDLE;
            res[0]   = mk(8'h00, KIND_ERROR, ERR_CTRL_CHAR);
            nres     = 3'd1;
          end else begin
            res[0] = mk(in_text_byte, KIND_BYTE, ERR_NONE);
            nres   = 3'd1;
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_BODY;
          nres     = 3'd1;
          case (in_text_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: res[0] = mk(in_text_byte, KIND_BYTE, ERR_NONE);
            8'h62: res[0] = mk(8'h08, KIND_BYTE, ERR_NONE);
            8'h66: res[0] = mk(8'h0C, KIND_BYTE, ERR_NONE);
            8'h6E: res[0] = mk(8'h0A, KIND_BYTE, ERR_NONE);
            8'h72: res[0] = mk(8'h0D, KIND_BYTE, ERR_NONE);
            8'h74: res[0] = mk(8'h09, KIND_BYTE, ERR_NONE);
            CH_U: begin
              mode_nxt = MODE_HEX;
              hex_nxt  = '0;
              hcnt_nxt = '0;
              nres     = 3'd0;
            end
            8'h00: begin
              mode_nxt = MODE_IDLE;
              res[0]   = mk(8'h00, KIND_ERROR, ERR_NO_QUOTE);
            end
            default: begin
              mode_nxt = MODE_IDLE;
              res[0]   = mk(8'h00, KIND_ERROR, ERR_BAD_ESC);
            end
          endcase
        end
        MODE_HEX, MODE_HEX2: begin
          if (!hd[4]) begin
            mode_nxt = MODE_IDLE;
            res[0]   = mk(8'h00, KIND_ERROR, ERR_BAD_HEX);
            nres     = 3'd1;
          end else if (hcnt_r != 2'd3) begin
            hex_nxt  = full;
            hcnt_nxt = hcnt_r + 2'd1;
          end else begin
            hex_nxt  = '0;
            hcnt_nxt = '0;
            if (mode_r == MODE_HEX && full >= SURR_HI_LO && full <= SURR_HI_HI) begin
              hsur_nxt = full[9:0];
              mode_nxt = MODE_WANT_BS;
            end else if (mode_r == MODE_HEX2 && (full < SURR_LO_LO || full > SURR_LO_HI)) begin
              mode_nxt = MODE_IDLE;
              res[0]   = mk(8'h00, KIND_ERROR, ERR_BAD_SURR);
              nres     = 3'd1;
            end else begin
              mode_nxt = MODE_BODY;
              if (mode_r == MODE_HEX2) begin
                cp       = surr_cp;
                hsur_nxt = '0;
              end
              // UTF-8 encode the code point
              if (cp <= 21'h7F) begin
                res[0] = mk(cp[7:0], KIND_BYTE, ERR_NONE);
                nres   = 3'd1;
              end else if (cp <= 21'h7FF) begin
                res[0] = mk({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE);
                res[1] = mk({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
                nres   = 3'd2;
              end else if (cp <= 21'hFFFF) begin
                res[0] = mk({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE);
                res[1] = mk({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
                res[2] = mk({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
                nres   = 3'd3;
              end else begin
                res[0] = mk({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NONE);
                res[1] = mk({2'b10, cp[17:12]}, KIND_BYTE, ERR_NONE);
                res[2] = mk({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
                res[3] = mk({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
                nres   = 3'd4;
              end
            end
          end
        end
        MODE_WANT_BS: begin
          if (in_text_byte == CH_BSLASH) begin
            mode_nxt = MODE_WANT_U;
          end else begin
            mode_nxt = MODE_IDLE;
            res[0]   = mk(8'h00, KIND_ERROR, ERR_BAD_SURR);
            nres     = 3'd1;
          end
        end
        MODE_WANT_U: begin
          if (in_text_byte == CH_U) begin
            mode_nxt = MODE_HEX2;
            hex_nxt  = '0;
            hcnt_nxt = '0;
          end else begin
            mode_nxt = MODE_IDLE;
            res[0]   = mk(8'h00, KIND_ERROR, ERR_BAD_SURR);
            nres     = 3'd1;
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase
      // any error drops the partial escape state
      if (nres == 3'd1 && res[0].kind == KIND_ERROR) begin
        hex_nxt  = '0;
        hcnt_nxt = '0;
        hsur_nxt = '0;
      end
    end

    // flag the final result of this request
    for (int i = 0; i < 4; i++) begin
      if (nres == 3'(i + 1)) res[i].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      hex_r  <= '0;
      hcnt_r <= '0;
      hsur_r <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      hcnt_r <= hcnt_nxt;
      hsur_r <= hsur_nxt;
      rd_r   <= '0;
      cnt_r  <= nres;
    end else if (out_fire) begin
      rd_r  <= rd_r + 2'd1;
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // payload entries load with each request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 4; i++) buf_r[i] <= res[i];
    end
  end

  assign out_out_byte   = buf_r[rd_r].data;
  assign out_kind       = buf_r[rd_r].kind;
  assign out_error_code = buf_r[rd_r].code;
  assign out_last       = buf_r[rd_r].last;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result count out of range");

  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (cnt_r == 3'd0 || (cnt_r == 3'd1 && out_fire)))
    else $error("request taken over pending results");

  a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (cnt_r == 3'd1)))
    else $error("last flag does not match buffer fill");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_BYTE) |-> (out_last && rd_r == 2'd0))
    else $error("done or error result not alone");

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_start_req && nres != 3'd0 && res[0].kind == KIND_ERROR)
      |=> (mode_r == MODE_IDLE)) else $error("parser not idle after error");
`endif

endmodule
`default_nettype wire

### dv/json_string_unescape_utf8_test.sv
`timescale 1ns / 1ps
module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  // Escape letters and the bytes they stand for
  localparam logic [7:0] ESC_B = 8'h62;
  localparam logic [7:0] ESC_F = 8'h66;
  localparam logic [7:0] ESC_N = 8'h6E;
  localparam logic [7:0] ESC_R = 8'h72;
  localparam logic [7:0] ESC_T = 8'h74;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_FORMFEED = 8'h0C;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int HOLD_OFF_AFTER = 120;
  localparam int QUIET_TAIL_ITEMS = 40;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_req;
  } text_item_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_start_req = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;

  json_string_unescape_utf8 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  // Text bytes waiting to be offered, and decoded results waiting to arrive
  text_item_t text_queue[$];
  res_t       pending_decoded[$];
  res_t       step_out[$];

  // Decoder state as the parser should hold it
  mode_t       dec_mode = MODE_IDLE;
  logic [15:0] dec_hex = 16'h0000;
  logic [1:0]  dec_digits = 2'd0;
  logic [9:0]  dec_high = 10'd0;

  int items_total = 0;
  int items_accepted = 0;
  int idle_noise = 0;
  int start_count = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet_tail = 1'b0;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // {is_hex, nibble} of one text byte
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    logic [7:0] t;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      r = {1'b1, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

  task automatic stage(input kind_t k, input logic [7:0] d, input err_t c);
    res_t r;
    r.data = d;
    r.kind = k;
    r.code = c;
    r.last = 1'b0;
    step_out.push_back(r);
  endtask

  // Any error drops the string and returns the parser to idle
  task automatic raise_error(input err_t c);
    dec_mode = MODE_IDLE;
    dec_hex = 16'h0000;
    dec_digits = 2'd0;
    dec_high = 10'd0;
    stage(KIND_ERROR, 8'h00, c);
  endtask

  task automatic encode_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      stage(KIND_BYTE, cp[7:0], ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      stage(KIND_BYTE, {3'b110, cp[10:6]}, ERR_NONE);
      stage(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      stage(KIND_BYTE, {4'b1110, cp[15:12]}, ERR_NONE);
      stage(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
      stage(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end else begin
      stage(KIND_BYTE, {5'b11110, cp[20:18]}, ERR_NONE);
      stage(KIND_BYTE, {2'b10, cp[17:12]}, ERR_NONE);
      stage(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
      stage(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end
  endtask

  // Advance the decoder by one accepted text byte and queue what it yields
  task automatic decode_text_byte(input logic [7:0] b, input logic st);
    logic [4:0]  nib;
    logic [15:0] cp16;
    logic [20:0] cp;
    step_out.delete();
    if (st) begin
      // opening quote: whatever was in flight is dropped, byte ignored
      dec_mode = MODE_BODY;
      dec_hex = 16'h0000;
      dec_digits = 2'd0;
      dec_high = 10'd0;
    end else begin
      case (dec_mode)
        MODE_BODY: begin
          if (b == CH_QUOTE) begin
            dec_mode = MODE_IDLE;
            stage(KIND_DONE, 8'h00, ERR_NONE);
          end else if (b == CH_BSLASH) begin
            dec_mode = MODE_ESC;
          end else if (b == CH_NUL) begin
            raise_error(ERR_NO_QUOTE);
          end else if (b < CH_SPACE) begin
            raise_error(ERR_CTRL_CHAR);
          end else begin
            stage(KIND_BYTE, b, ERR_NONE);
          end
        end
        MODE_ESC: begin
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
              dec_mode = MODE_BODY;
              stage(KIND_BYTE, b, ERR_NONE);
            end
            ESC_B: begin
              dec_mode = MODE_BODY;
              stage(KIND_BYTE, CH_BACKSPACE, ERR_NONE);
            end
            ESC_F: begin
              dec_mode = MODE_BODY;
              stage(KIND_BYTE, CH_FORMFEED, ERR_NONE);
            end
            ESC_N: begin
              dec_mode = MODE_BODY;
              stage(KIND_BYTE, CH_LF, ERR_NONE);
            end
            ESC_R: begin
              dec_mode = MODE_BODY;
              stage(KIND_BYTE, CH_CR, ERR_NONE);
            end
            ESC_T: begin
              dec_mode = MODE_BODY;
              stage(KIND_BYTE, CH_TAB, ERR_NONE);
            end
            CH_U: begin
              dec_mode = MODE_HEX;
              dec_hex = 16'h0000;
              dec_digits = 2'd0;
            end
            CH_NUL: raise_error(ERR_NO_QUOTE);
            default: raise_error(ERR_BAD_ESC);
          endcase
        end
        MODE_HEX, MODE_HEX2: begin
          nib = hex_nibble(b);
          if (!nib[4]) begin
            raise_error(ERR_BAD_HEX);
          end else begin
            dec_hex = {dec_hex[11:0], nib[3:0]};
            if (dec_digits != 2'd3) begin
              dec_digits = dec_digits + 2'd1;
            end else begin
              dec_digits = 2'd0;
              cp16 = dec_hex;
              dec_hex = 16'h0000;
              if (dec_mode == MODE_HEX) begin
                if (cp16 >= SURR_HI_LO && cp16 <= SURR_HI_HI) begin
                  // high half: wait for the low half
                  dec_high = cp16[9:0];
                  dec_mode = MODE_WANT_BS;
                end else begin
                  // a lone low half is encoded like any other BMP value
                  dec_mode = MODE_BODY;
                  encode_utf8({5'd0, cp16});
                end
              end else if (cp16 < SURR_LO_LO || cp16 > SURR_LO_HI) begin
                raise_error(ERR_BAD_SURR);
              end else begin
                cp = {1'b0, dec_high, cp16[9:0]} + SUPP_BASE;
                dec_high = 10'd0;
                dec_mode = MODE_BODY;
                encode_utf8(cp);
              end
            end
          end
        end
        MODE_WANT_BS: begin
          if (b != CH_BSLASH) raise_error(ERR_BAD_SURR);
          else dec_mode = MODE_WANT_U;
        end
        MODE_WANT_U: begin
          if (b != CH_U) begin
            raise_error(ERR_BAD_SURR);
          end else begin
            dec_mode = MODE_HEX2;
            dec_hex = 16'h0000;
            dec_digits = 2'd0;
          end
        end
        default: dec_mode = MODE_IDLE;  // idle: byte ignored
      endcase
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) pending_decoded.push_back(step_out[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] result %0d: %s is %0h, expected %0h",
               $realtime, results_checked, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic feed(input logic [7:0] b, input logic st);
    text_item_t t;
    t.text_byte = b;
    t.start_req = st;
    text_queue.push_back(t);
    if (st) start_count++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + n;
    else if (upper) r = 8'h37 + n;
    else r = 8'h57 + n;
    return r;
  endfunction

  // Queue a \uXXXX escape, digit case picked at random
  task automatic push_u(input logic [15:0] v);
    feed(CH_BSLASH, 1'b0);
    feed(CH_U, 1'b0);
    feed(hex_char(v[15:12], 1'($urandom_range(0, 1))), 1'b0);
    feed(hex_char(v[11:8], 1'($urandom_range(0, 1))), 1'b0);
    feed(hex_char(v[7:4], 1'($urandom_range(0, 1))), 1'b0);
    feed(hex_char(v[3:0], 1'($urandom_range(0, 1))), 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Driver: offer queued text bytes, idling in random bursts.
  // Hold payload steady while valid is up and the request is not taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : driver
    text_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (text_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
          // start an idle burst, this one included
          send_gap <= $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else begin
          nxt = text_queue.pop_front();
          in_text_byte <= nxt.text_byte;
          in_start_req <= nxt.start_req;
          in_valid <= 1'b1;
        end
      end
      // drop all idling near the end of the stimulus
      quiet_tail <= (text_queue.size() < QUIET_TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall in random bursts, and once hold off for a long stretch
  // while the driver keeps offering, so the result buffer fills and the
  // block has to stall its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && items_accepted >= HOLD_OFF_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on every accepted text byte, then check every
  // accepted result against the oldest pending one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_text_byte(in_text_byte, in_start_req);
        items_accepted <= items_accepted + 1;
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_decoded.size() == 0) begin
          report_mismatch("result with nothing pending, kind", 32'(out_kind), 32'd0);
        end else begin
          want = pending_decoded.pop_front();
          if (out_kind !== want.kind) begin
            report_mismatch("kind", 32'(out_kind), 32'(want.kind));
          end
          if (out_out_byte !== want.data) begin
            report_mismatch("out_byte", 32'(out_out_byte), 32'(want.data));
          end
          if (out_error_code !== want.code) begin
            report_mismatch("error_code", 32'(out_error_code), 32'(want.code));
          end
          if (out_last !== want.last) begin
            report_mismatch("last", 32'(out_last), 32'(want.last));
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_decoded.size());
      $display("json_string_unescape_utf8_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  b;
    logic [15:0] v;
    logic [4:0]  nib;
    int frags;
    int pick;
    int k;

    // Directed: idle byte, start with max byte, plain extremes, an escape,
    // \u0000, the largest surrogate pair, close; then control char and
    // zero after backslash.
    feed(8'h5A, 1'b0);
    idle_noise++;
    feed(8'hFF, 1'b1);
    feed(CH_SPACE, 1'b0);
    feed(8'hFF, 1'b0);
    feed(CH_BSLASH, 1'b0);
    feed(ESC_N, 1'b0);
    push_u(16'h0000);
    push_u(SURR_HI_HI);
    push_u(SURR_LO_HI);
    feed(CH_QUOTE, 1'b0);
    feed(CH_NUL, 1'b1);
    feed(8'h1F, 1'b0);
    feed(8'h80, 1'b1);
    feed(CH_BSLASH, 1'b0);
    feed(CH_NUL, 1'b0);

    // Random strings: mostly well-formed bodies, ended by a close, an
    // error, a fresh start mid-escape, or raw noise.
    while (text_queue.size() - idle_noise < 220) begin
      feed(8'($urandom_range(0, 255)), 1'b1);
      frags = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      repeat (frags) begin
        pick = $urandom_range(0, 6);
        case (pick)
          0, 1, 2: begin
            b = 8'($urandom_range(8'h20, 8'hFF));
            if (b == CH_QUOTE || b == CH_BSLASH) b = b + 8'd1;
            feed(b, 1'b0);
          end
          3: begin
            feed(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 7))
              0: b = CH_QUOTE;
              1: b = CH_BSLASH;
              2: b = CH_SLASH;
              3: b = ESC_B;
              4: b = ESC_F;
              5: b = ESC_N;
              6: b = ESC_R;
              default: b = ESC_T;
            endcase
            feed(b, 1'b0);
          end
          4: begin
            case ($urandom_range(0, 4))
              0: v = 16'($urandom_range(0, 16'h7F));
              1: v = 16'($urandom_range(16'h80, 16'h7FF));
              2: v = 16'($urandom_range(16'h800, 16'hD7FF));
              3: v = 16'($urandom_range(16'hE000, 16'hFFFF));
              default: v = 16'($urandom_range(SURR_LO_LO, SURR_LO_HI));  // lone low half
            endcase
            push_u(v);
          end
          default: begin
            push_u(16'($urandom_range(SURR_HI_LO, SURR_HI_HI)));
            push_u(16'($urandom_range(SURR_LO_LO, SURR_LO_HI)));
          end
        endcase
      end

      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        feed(CH_QUOTE, 1'b0);
      end else if (pick == 10) begin
        feed(CH_NUL, 1'b0);  // text ends inside the string
      end else if (pick == 11) begin
        feed(8'($urandom_range(1, 8'h1F)), 1'b0);
      end else if (pick == 12) begin
        // bad escape letter, zero included
        feed(CH_BSLASH, 1'b0);
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == ESC_B ||
                   b == ESC_F || b == ESC_N || b == ESC_R || b == ESC_T || b == CH_U);
        feed(b, 1'b0);
      end else if (pick == 13) begin
        // non-hex byte at a random digit position
        feed(CH_BSLASH, 1'b0);
        feed(CH_U, 1'b0);
        k = $urandom_range(0, 3);
        repeat (k) begin
          feed(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
        end
        if ($urandom_range(0, 3) == 0) begin
          b = CH_NUL;
        end else begin
          do begin
            b = 8'($urandom_range(1, 255));
            nib = hex_nibble(b);
          end while (nib[4]);
        end
        feed(b, 1'b0);
      end else if (pick == 14) begin
        // high half without a proper low half
        push_u(16'($urandom_range(SURR_HI_LO, SURR_HI_HI)));
        case ($urandom_range(0, 2))
          0: begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
            feed(b, 1'b0);
          end
          1: begin
            feed(CH_BSLASH, 1'b0);
            do b = 8'($urandom_range(0, 255)); while (b == CH_U);
            feed(b, 1'b0);
          end
          default: begin
            if ($urandom_range(0, 1) == 1) v = 16'($urandom_range(0, 16'hDBFF));
            else v = 16'($urandom_range(16'hE000, 16'hFFFF));
            push_u(v);
          end
        endcase
      end else if (pick < 17) begin
        // leave an escape half done; the next start cuts it off
        case ($urandom_range(0, 3))
          0: feed(CH_BSLASH, 1'b0);
          1: begin
            feed(CH_BSLASH, 1'b0);
            feed(CH_U, 1'b0);
            repeat ($urandom_range(0, 3)) begin
              feed(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
            end
          end
          2: push_u(16'($urandom_range(SURR_HI_LO, SURR_HI_HI)));
          default: begin
            push_u(16'($urandom_range(SURR_HI_LO, SURR_HI_HI)));
            feed(CH_BSLASH, 1'b0);
            if ($urandom_range(0, 1) == 1) feed(CH_U, 1'b0);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) feed(8'($urandom_range(0, 255)), 1'b0);
      end

      // the parser is idle after a close or an error: a stray byte is ignored
      if (pick <= 14 && $urandom_range(0, 5) == 0) begin
        feed(8'($urandom_range(0, 255)), 1'b0);
        idle_noise++;
      end
    end
    items_total = text_queue.size();

    // Hold reset, then release
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every byte taken, every result back, then a short tail
    while (items_accepted != items_total) @(posedge clk);
    while (pending_decoded.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d text bytes in %0d strings (plain, escapes, surrogates, errors)",
             items_total, start_count);
    $display("checked %0d results across one long output hold-off, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("json_string_unescape_utf8_test: PASS");
    end else begin
      $display("json_string_unescape_utf8_test: FAIL");
    end
    $finish;
  end

endmodule
